@@ sv/urldec_pkg.sv @@
package urldec_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [3:0] HEX_TEN    = 4'd10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } urldec_word_t;

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] diff;
    begin
      diff = 8'h00;
      if (b >= CH_ZERO && b <= CH_NINE) begin
        diff = b - CH_ZERO;
        hex_value = diff[3:0];
      end else if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
        diff = b - CH_UPPER_A;
        hex_value = diff[3:0] + HEX_TEN;
      end else if (b >= CH_LOWER_A && b <= CH_LOWER_F) begin
        diff = b - CH_LOWER_A;
        hex_value = diff[3:0] + HEX_TEN;
      end else begin
        hex_value = 4'h0;
      end
    end
  endfunction

endpackage

@@ sv/url_percent_decoder.sv @@
// url percent decoder
// input channel: in_valid/in_ready carry one encoded byte (in_byte) and an
//   end-of-string mark (in_last) per word
// output channel: out_valid/out_ready carry one result word per input word:
//   has_byte says whether out_byte holds a decoded byte, out_last echoes in_last
// config channel: cfg_valid/cfg_ready write keep_high_bytes from cfg_data;
//   cfg_ready is always high, write only while no word is in flight
// '+' gives a space, '%' opens a two-digit hex escape, other bytes pass through;
//   decoded values below 0x20, and 0x80-0xff unless keep_high_bytes, give '?'
// path: an accepted word goes into the input register, then is decoded into
//   the result register, which drives the output
// throughput: one word per cycle while out_ready is high, set by the single decode stage
// reset: clears the escape state, keep_high_bytes and both valid flags
// a stalled receiver holds the result register; one more word still enters
//   the input register, then in_ready drops until out_ready returns
module url_percent_decoder
  import urldec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       has_byte,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic         keep_high_bytes;
  logic         s_valid;
  logic         s_ready;
  urldec_word_t in_word;
  urldec_word_t s_word;

  assign cfg_ready    = 1'b1;
  assign in_word.data = in_byte;
  assign in_word.last = in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_high_bytes <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      keep_high_bytes <= cfg_data;
    end
  end

  urldec_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_word   (s_word)
  );

  urldec_decode u_decode (
    .clk             (clk),
    .rst             (rst),
    .keep_high_bytes (keep_high_bytes),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_word          (s_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .has_byte        (has_byte),
    .out_byte        (out_byte),
    .out_last        (out_last)
  );

endmodule

@@ sv/urldec_in_reg.sv @@
module urldec_in_reg
  import urldec_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  urldec_word_t in_word,
  output logic         s_valid,
  input  logic         s_ready,
  output urldec_word_t s_word
);

  logic         valid;
  urldec_word_t word;

  assign in_ready = !valid || s_ready;
  assign s_valid  = valid;
  assign s_word   = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= in_word;
    end
  end

endmodule

@@ sv/urldec_decode.sv @@
module urldec_decode
  import urldec_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         keep_high_bytes,
  input  logic         s_valid,
  output logic         s_ready,
  input  urldec_word_t s_word,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         has_byte,
  output logic [7:0]   out_byte,
  output logic         out_last
);

  logic       in_escape, in_escape_next;
  logic       digits_seen, digits_seen_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       valid;
  logic       has, has_next;
  logic [7:0] ob, ob_next;
  logic       last;
  logic       advance;
  logic [3:0] digit;
  logic [7:0] value;
  logic       bad;

  assign s_ready   = !valid || out_ready;
  assign advance   = s_valid && s_ready;
  assign out_valid = valid;
  assign has_byte  = has;
  assign out_byte  = ob;
  assign out_last  = last;

  assign digit = hex_value(s_word.data);
  assign value = {high_nibble, digit};
  assign bad   = (value < CH_SPACE) || (value[7] && !keep_high_bytes);

  always_comb begin
    in_escape_next   = in_escape;
    digits_seen_next = digits_seen;
    high_nibble_next = high_nibble;
    has_next         = 1'b0;
    ob_next          = 8'h00;
    if (s_word.data == CH_PLUS) begin
      has_next = 1'b1;
      ob_next  = CH_SPACE;
    end else if (s_word.data == CH_PERCENT) begin
      in_escape_next   = 1'b1;
      digits_seen_next = 1'b0;
      high_nibble_next = 4'h0;
    end else if (in_escape) begin
      if (!digits_seen) begin
        high_nibble_next = digit;
        digits_seen_next = 1'b1;
      end else begin
        has_next         = 1'b1;
        ob_next          = bad ? CH_QMARK : value;
        in_escape_next   = 1'b0;
        digits_seen_next = 1'b0;
        high_nibble_next = 4'h0;
      end
    end else begin
      has_next = 1'b1;
      ob_next  = s_word.data;
    end
    // end of string drops any open escape
    if (s_word.last) begin
      in_escape_next   = 1'b0;
      digits_seen_next = 1'b0;
      high_nibble_next = 4'h0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_escape   <= 1'b0;
      digits_seen <= 1'b0;
      high_nibble <= 4'h0;
      valid       <= 1'b0;
    end else begin
      if (advance) begin
        in_escape   <= in_escape_next;
        digits_seen <= digits_seen_next;
        high_nibble <= high_nibble_next;
      end
      if (s_ready) begin
        valid <= s_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      has  <= has_next;
      ob   <= ob_next;
      last <= s_word.last;
    end
  end

endmodule

@@ test/url_percent_decoder_tb.sv @@
module url_percent_decoder_tb;
  import urldec_pkg::*;

  typedef struct packed {
    logic       has;
    logic [7:0] data;
    logic       last;
  } decoded_t;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic       has_byte;
  logic [7:0] out_byte;
  logic       out_last;

  // decoder state as predicted
  logic       keep_high;
  logic       esc_open;
  logic       digit_held;
  logic [3:0] held_nibble;

  decoded_t pending_decodes[$];

  int  errors;
  int  words_sent;
  int  words_checked;
  int  escapes_sent;
  int  cfg_writes;
  int  input_stalls;
  bit  no_idle;
  int  hold_request;

  url_percent_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .has_byte  (has_byte),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return c[3:0];
    end
    if ((c >= CH_UPPER_A && c <= CH_UPPER_F) || (c >= CH_LOWER_A && c <= CH_LOWER_F)) begin
      return c[3:0] + 4'd9;
    end
    return 4'h0;
  endfunction

  function automatic decoded_t decode_byte(input logic [7:0] b, input logic l);
    decoded_t   r;
    logic [7:0] v;
    r = '0;
    r.last = l;
    if (b == CH_PLUS) begin
      r.has = 1'b1;
      r.data = CH_SPACE;
    end else if (b == CH_PERCENT) begin
      esc_open = 1'b1;
      digit_held = 1'b0;
      held_nibble = 4'h0;
    end else if (esc_open) begin
      if (!digit_held) begin
        held_nibble = nibble_of(b);
        digit_held = 1'b1;
      end else begin
        v = {held_nibble, nibble_of(b)};
        r.has = 1'b1;
        r.data = (v < CH_SPACE || (v[7] && !keep_high)) ? CH_QMARK : v;
        esc_open = 1'b0;
        digit_held = 1'b0;
        held_nibble = 4'h0;
      end
    end else begin
      r.has = 1'b1;
      r.data = b;
    end
    if (l) begin
      esc_open = 1'b0;
      digit_held = 1'b0;
      held_nibble = 4'h0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [7:0] hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 8'd10) begin
      return CH_ZERO + v;
    end
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + v - 8'd10;
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    if (errors <= 25) begin
      $display("mismatch %s: got %0h, expected %0h (word %0d)", what, got, want,
               words_checked);
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic l);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte = b;
    in_last = l;
    do @(posedge clk); while (!in_ready);
    pending_decodes.push_back(decode_byte(b, l));
    words_sent++;
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++) begin
      send_word(t[i], i == t.len() - 1);
    end
  endtask

  task automatic drain_decoder();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic write_keep_high(input logic v);
    drain_decoder();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    keep_high = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_strings(input int n);
    logic [7:0] s[$];
    int         total;
    int         len;
    int         r;
    total = 0;
    while (total < n) begin
      s = {};
      len = $urandom_range(1, 12);
      while (s.size() < len) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          s.push_back(CH_PERCENT);
          s.push_back(hex_char());
          s.push_back(hex_char());
          escapes_sent++;
        end else if (r < 55) begin
          s.push_back(CH_PLUS);
        end else if (r < 80) begin
          s.push_back(8'($urandom_range(8'h20, 8'h7e)));
        end else if (r < 90) begin
          s.push_back(8'($urandom_range(0, 255)));
        end else if (r < 95) begin
          // broken escape, one digit only
          s.push_back(CH_PERCENT);
          s.push_back(hex_char());
        end else begin
          s.push_back(CH_PERCENT);
        end
      end
      foreach (s[i]) begin
        send_word(s[i], i == s.size() - 1);
      end
      total += s.size();
    end
  endtask

  task automatic test_raw_bytes();
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(CH_PLUS, 1'b1);
  endtask

  task automatic test_escapes();
    send_text("%41");
    send_text("%4%7e");
    send_text("%4+1");
    send_text("%7");
    send_text("%G0");
    send_text("%FF");
  endtask

  task automatic test_keep_high();
    write_keep_high(1'b1);
    send_text("%fe");
    send_text("%80");
  endtask

  task automatic test_random_strings();
    for (int phase = 0; phase < 4; phase++) begin
      write_keep_high(phase[0]);
      no_idle = (phase == 2);
      send_random_strings(165);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    drain_decoder();
    hold_request = 60;
    no_idle = 1'b1;
    send_random_strings(40);
    no_idle = 1'b0;
  endtask

  // receiver side
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (no_idle || $urandom_range(0, 99) < 70) begin
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (!rst) begin
      if (in_valid && !in_ready) begin
        input_stalls++;
      end
      if (out_valid && out_ready) begin
        if (pending_decodes.size() == 0) begin
          report("unexpected word", {has_byte, out_byte, out_last}, 0);
        end else begin
          want = pending_decodes.pop_front();
          if (has_byte !== want.has) begin
            report("has_byte", has_byte, want.has);
          end
          if (out_byte !== want.data) begin
            report("out_byte", out_byte, want.data);
          end
          if (out_last !== want.last) begin
            report("out_last", out_last, want.last);
          end
        end
        words_checked++;
      end
    end
  end

  initial begin
    #5000000;
    $display("timeout");
    $display("url_percent_decoder_tb: FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    in_last = 1'b0;
    keep_high = 1'b0;
    esc_open = 1'b0;
    digit_held = 1'b0;
    held_nibble = 4'h0;
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    escapes_sent = 0;
    cfg_writes = 0;
    input_stalls = 0;
    no_idle = 1'b0;
    hold_request = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_raw_bytes();
    test_escapes();
    test_keep_high();
    test_random_strings();
    test_backpressure();

    drain_decoder();
    repeat (8) @(posedge clk);
    if (pending_decodes.size() != 0) begin
      report("words never returned", pending_decodes.size(), 0);
    end
    $display("sent %0d words (%0d full escapes), checked %0d results", words_sent,
             escapes_sent, words_checked);
    $display("%0d keep_high_bytes writes, %0d cycles with input held off", cfg_writes,
             input_stalls);
    if (errors == 0) begin
      $display("url_percent_decoder_tb: PASS");
    end else begin
      $display("url_percent_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/urldec_pkg.sv
sv/urldec_in_reg.sv
sv/urldec_decode.sv
sv/url_percent_decoder.sv
test/url_percent_decoder_tb.sv
